// ===== rtl/mthw_pkg.sv =====
// Shared constants and types for the multi-task heartbeat watchdog.
package mthw_pkg;

	localparam int NUM_TASKS = 8;
	localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int TCNT_W    = $clog2(NUM_TASKS + 1);

	localparam int TIME_W = 48;
	localparam int TOUT_W = 32;
	localparam int FAIL_W = 8;
	localparam int IDX_W  = 4;
	localparam int RSN_W  = 2;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 16;

	localparam logic [TOUT_W-1:0] TASK_TIMEOUT_RST   = 32'd10000000;
	localparam logic [TOUT_W-1:0] GRACE_PERIOD_RST   = 32'd30000000;
	localparam logic [FAIL_W-1:0] FAIL_THRESHOLD_RST = 8'd3;
	localparam logic [TIME_W-1:0] START_TIME_RST     = 48'd0;

	localparam logic [1:0] CFG_TASK_TIMEOUT   = 2'd0;
	localparam logic [1:0] CFG_GRACE_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_FAIL_THRESHOLD = 2'd2;
	localparam logic [1:0] CFG_START_TIME     = 2'd3;

	localparam logic CMD_HEARTBEAT = 1'b0;
	localparam logic CMD_CHECK     = 1'b1;

	localparam logic [RSN_W-1:0] REASON_NONE         = 2'd0;
	localparam logic [RSN_W-1:0] REASON_UI_FROZEN    = 2'd1;
	localparam logic [RSN_W-1:0] REASON_TASK_STALLED = 2'd2;

	localparam logic [FAIL_W-1:0] FAIL_MAX = 8'hFF;

	typedef struct packed {
		logic [FAIL_W-1:0] fail_count;
		logic [IDX_W-1:0]  stalled_task;
		logic [RSN_W-1:0]  reset_reason;
	} result_t;

endpackage

// ===== rtl/multi_task_heartbeat_watchdog_core.sv =====
// Multi-task heartbeat watchdog: timestamp memory, failure counter and stall scan.
//
//   channel  dir  handshake               payload
//   s_*      in   s_tvalid / s_tready     tuser: cmd; tdata: task_index, now_time, lock_ok
//   m_*      out  m_tvalid / m_tready     tdata: reset_reason, stalled_task, fail_count
//   cfg_*    in   cfg_we                  cfg_index, cfg_data
//
// A heartbeat, or a check that ends in the grace window or in a UI-frozen request,
// goes from idle straight to the finish state. A check that scans passes through the scan
// state: the timestamp memory is read one task per cycle through its single, registered read port.
// Reset clears the valid bits, failure counter and state registers; no clearing pass is needed.
// A full output register holds the finished result and the next transaction waits.
module multi_task_heartbeat_watchdog_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mthw_pkg::S_TDATA_W-1:0]    s_tdata,  // task_index[3:0], now_time[51:4], lock_ok[52]
	input  logic                              s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mthw_pkg::M_TDATA_W-1:0]    m_tdata,  // reset_reason[1:0], stalled_task[5:2], fail_count[13:6]
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [mthw_pkg::TIME_W-1:0]       cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam int TW = mthw_pkg::TASK_W;
	localparam int CW = mthw_pkg::TCNT_W;
	localparam logic [CW-1:0] SCAN_END  = CW'(mthw_pkg::NUM_TASKS);
	localparam logic [TW-1:0] LAST_TASK = TW'(mthw_pkg::NUM_TASKS - 1);

	logic [1:0] state_q;

	logic [mthw_pkg::TOUT_W-1:0] task_timeout_q;
	logic [mthw_pkg::TOUT_W-1:0] grace_period_q;
	logic [mthw_pkg::FAIL_W-1:0] fail_threshold_q;
	logic [mthw_pkg::TIME_W-1:0] start_time_q;

	logic [mthw_pkg::TIME_W-1:0] beat_mem [mthw_pkg::NUM_TASKS];
	logic [mthw_pkg::NUM_TASKS-1:0] beat_valid_q;
	logic [mthw_pkg::FAIL_W-1:0] fail_cnt_q;

	logic [mthw_pkg::TIME_W-1:0] now_q;
	logic [CW-1:0]               scan_q;
	logic                        chk_valid_s1;
	logic [TW-1:0]               chk_idx_s1;
	logic [mthw_pkg::TIME_W-1:0] rd_data_s1;
	mthw_pkg::result_t           res_q;

	logic                         in_cmd;
	logic [mthw_pkg::IDX_W-1:0]   in_idx;
	logic [mthw_pkg::TIME_W-1:0]  in_now;
	logic                         in_lock;
	logic                         accept;
	logic                         hb_write;
	logic [mthw_pkg::TIME_W-1:0]  since_start;
	logic                         grace_win;
	logic [mthw_pkg::FAIL_W-1:0]  cnt_inc;
	logic [mthw_pkg::FAIL_W-1:0]  cnt_next;
	logic                         ui_frozen;
	logic [mthw_pkg::TIME_W-1:0]  age;
	logic                         hit;
	logic                         scan_done;
	logic                         issue;
	logic                         out_free;

	assign in_idx  = s_tdata[3:0];
	assign in_now  = s_tdata[51:4];
	assign in_lock = s_tdata[52];
	assign in_cmd  = s_tuser;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign hb_write = accept && (in_cmd == mthw_pkg::CMD_HEARTBEAT) &&
		({1'b0, in_idx} < 5'(mthw_pkg::NUM_TASKS));

	assign since_start = in_now - start_time_q;
	assign grace_win = (in_now < start_time_q) ||
		(since_start < {16'd0, grace_period_q});
	assign cnt_inc = (fail_cnt_q < mthw_pkg::FAIL_MAX) ? fail_cnt_q + 8'd1 : fail_cnt_q;

	always_comb begin
		cnt_next  = fail_cnt_q;
		ui_frozen = 1'b0;
		if (in_lock) begin
			cnt_next = '0;
		end else if (!grace_win) begin
			cnt_next  = cnt_inc;
			ui_frozen = (cnt_inc >= fail_threshold_q);
		end
	end

	assign age       = now_q - rd_data_s1;
	assign hit       = chk_valid_s1 && beat_valid_q[chk_idx_s1] && (now_q >= rd_data_s1) &&
		(age > {16'd0, task_timeout_q});
	assign scan_done = chk_valid_s1 && (hit || (chk_idx_s1 == LAST_TASK));
	assign issue     = (state_q == ST_SCAN) && !scan_done && (scan_q < SCAN_END);
	assign out_free  = !m_tvalid || m_tready;

	// timestamp memory: one write port at accept, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (hb_write) begin
			beat_mem[in_idx[TW-1:0]] <= in_now;
		end
		rd_data_s1 <= beat_mem[scan_q[TW-1:0]];
		chk_idx_s1 <= scan_q[TW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_timeout_q   <= mthw_pkg::TASK_TIMEOUT_RST;
			grace_period_q   <= mthw_pkg::GRACE_PERIOD_RST;
			fail_threshold_q <= mthw_pkg::FAIL_THRESHOLD_RST;
			start_time_q     <= mthw_pkg::START_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mthw_pkg::CFG_TASK_TIMEOUT:   task_timeout_q   <= cfg_data[31:0];
				mthw_pkg::CFG_GRACE_PERIOD:   grace_period_q   <= cfg_data[31:0];
				mthw_pkg::CFG_FAIL_THRESHOLD: fail_threshold_q <= cfg_data[7:0];
				mthw_pkg::CFG_START_TIME:     start_time_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			beat_valid_q <= '0;
			fail_cnt_q   <= '0;
			scan_q       <= '0;
			chk_valid_s1 <= 1'b0;
			res_q        <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
		end else begin
			chk_valid_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + CW'(1);
			end
			if (m_tvalid && m_tready && (state_q != ST_FIN)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q.stalled_task <= '0;
						scan_q             <= '0;
						if (in_cmd == mthw_pkg::CMD_HEARTBEAT) begin
							if (hb_write) begin
								beat_valid_q[in_idx[TW-1:0]] <= 1'b1;
							end
							res_q.reset_reason <= mthw_pkg::REASON_NONE;
							res_q.fail_count   <= fail_cnt_q;
							state_q <= ST_FIN;
						end else begin
							fail_cnt_q       <= cnt_next;
							res_q.fail_count <= cnt_next;
							if (ui_frozen) begin
								res_q.reset_reason <= mthw_pkg::REASON_UI_FROZEN;
								state_q <= ST_FIN;
							end else begin
								res_q.reset_reason <= mthw_pkg::REASON_NONE;
								if (grace_win) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_SCAN;
								end
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (hit) begin
							res_q.reset_reason <= mthw_pkg::REASON_TASK_STALLED;
							res_q.stalled_task <= mthw_pkg::IDX_W'(chk_idx_s1);
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {2'b00, res_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the multi-task heartbeat watchdog core.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [mthw_pkg::TIME_W-1:0] TIME_MAX = '1;
	localparam logic [mthw_pkg::TOUT_W-1:0] TOUT_MAX = '1;

	// Tracks the watchdog state and holds the verdicts still to come out of the core.
	class heartbeat_scoreboard;
		logic [mthw_pkg::TIME_W-1:0] beat_time [mthw_pkg::NUM_TASKS];
		bit                          beat_seen [mthw_pkg::NUM_TASKS];
		logic [mthw_pkg::FAIL_W-1:0] fail_run;
		logic [mthw_pkg::TOUT_W-1:0] timeout_us;
		logic [mthw_pkg::TOUT_W-1:0] grace_len;
		logic [mthw_pkg::FAIL_W-1:0] threshold;
		logic [mthw_pkg::TIME_W-1:0] base_time;
		mthw_pkg::result_t           verdict_q [$];
		int                          errors;
		int                          events_seen;
		int                          checks_seen;
		int                          verdicts_seen;
		int                          frozen_seen;
		int                          stall_seen;

		function new();
			for (int i = 0; i < mthw_pkg::NUM_TASKS; i++) begin
				beat_time[i] = '0;
				beat_seen[i] = 1'b0;
			end
			fail_run   = '0;
			timeout_us = 32'd10000000;
			grace_len  = 32'd30000000;
			threshold  = 8'd3;
			base_time  = '0;
			errors     = 0;
			events_seen = 0;
			checks_seen = 0;
			verdicts_seen = 0;
			frozen_seen = 0;
			stall_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [mthw_pkg::TIME_W-1:0] data);
			case (idx)
				mthw_pkg::CFG_TASK_TIMEOUT:   timeout_us = data[mthw_pkg::TOUT_W-1:0];
				mthw_pkg::CFG_GRACE_PERIOD:   grace_len  = data[mthw_pkg::TOUT_W-1:0];
				mthw_pkg::CFG_FAIL_THRESHOLD: threshold  = data[mthw_pkg::FAIL_W-1:0];
				mthw_pkg::CFG_START_TIME:     base_time  = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		function void accept_event(logic cmd, logic [mthw_pkg::IDX_W-1:0] idx,
				logic [mthw_pkg::TIME_W-1:0] now, logic lock);
			mthw_pkg::result_t r;
			logic              grace_win;
			bit                found;
			r = '0;
			found = 1'b0;
			events_seen++;
			if (cmd == mthw_pkg::CMD_HEARTBEAT) begin
				if (int'(idx) < mthw_pkg::NUM_TASKS) begin
					beat_time[int'(idx)] = now;
					beat_seen[int'(idx)] = 1'b1;
				end
			end else begin
				checks_seen++;
				grace_win = (now < base_time) || ((now - base_time) < {16'b0, grace_len});
				if (lock) begin
					fail_run = '0;
				end else if (!grace_win) begin
					if (fail_run != mthw_pkg::FAIL_MAX)
						fail_run = fail_run + 8'd1;
					if (fail_run >= threshold)
						r.reset_reason = mthw_pkg::REASON_UI_FROZEN;
				end
				if (!grace_win && r.reset_reason == mthw_pkg::REASON_NONE) begin
					for (int i = 0; i < mthw_pkg::NUM_TASKS; i++) begin
						if (!found && beat_seen[i] && now >= beat_time[i] &&
								(now - beat_time[i]) > {16'b0, timeout_us}) begin
							found = 1'b1;
							r.reset_reason = mthw_pkg::REASON_TASK_STALLED;
							r.stalled_task = mthw_pkg::IDX_W'(i);
						end
					end
				end
			end
			r.fail_count = fail_run;
			verdict_q.push_back(r);
		endfunction

		function void verify_verdict(logic [mthw_pkg::M_TDATA_W-1:0] data);
			mthw_pkg::result_t got;
			mthw_pkg::result_t want;
			got = data[$bits(mthw_pkg::result_t)-1:0];
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict %h, none expected", $time, data);
				errors++;
				return;
			end
			want = verdict_q.pop_front();
			if (got.reset_reason == mthw_pkg::REASON_UI_FROZEN) frozen_seen++;
			if (got.reset_reason == mthw_pkg::REASON_TASK_STALLED) stall_seen++;
			if (got.reset_reason !== want.reset_reason) begin
				$display("%0t: reset_reason expected %0d actual %0d", $time,
					want.reset_reason, got.reset_reason);
				errors++;
			end
			if (got.stalled_task !== want.stalled_task) begin
				$display("%0t: stalled_task expected %0d actual %0d", $time,
					want.stalled_task, got.stalled_task);
				errors++;
			end
			if (got.fail_count !== want.fail_count) begin
				$display("%0t: fail_count expected %0d actual %0d", $time,
					want.fail_count, got.fail_count);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [mthw_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [mthw_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           cfg_we = 1'b0;
	logic [1:0]                     cfg_index = '0;
	logic [mthw_pkg::TIME_W-1:0]    cfg_data = '0;

	heartbeat_scoreboard         sb = new();
	int                          idle_mode = 0;
	int                          cycles = 0;
	logic [mthw_pkg::TIME_W-1:0] now_cursor = '0;

	multi_task_heartbeat_watchdog_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_task_heartbeat_watchdog_core: mismatch");
			$finish;
		end
	end

	// idle modes: 0 none, 1 sender 84%, 2 receiver 84%, 3 both 12%
	always @(posedge clk) begin
		case (idle_mode)
			2:       m_tready <= ($urandom_range(99) >= 84);
			3:       m_tready <= ($urandom_range(99) >= 12);
			default: m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.verify_verdict(m_tdata);
	end

	function automatic bit sender_idles();
		case (idle_mode)
			1:       return $urandom_range(99) < 84;
			3:       return $urandom_range(99) < 12;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [mthw_pkg::TIME_W-1:0] rand_time();
		return mthw_pkg::TIME_W'({$urandom, $urandom});
	endfunction

	function automatic logic [mthw_pkg::TIME_W-1:0] rand_span(input int unsigned hi);
		return mthw_pkg::TIME_W'($urandom_range(hi));
	endfunction

	task automatic send_item(input logic cmd, input logic [mthw_pkg::IDX_W-1:0] idx,
			input logic [mthw_pkg::TIME_W-1:0] now, input logic lock);
		if (sender_idles()) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (sender_idles());
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b0, lock, now, idx};
		do @(posedge clk); while (!s_tready);
		sb.accept_event(cmd, idx, now, lock);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_config(input logic [mthw_pkg::TOUT_W-1:0] tout,
			input logic [mthw_pkg::TOUT_W-1:0] grace, input logic [mthw_pkg::FAIL_W-1:0] thresh,
			input logic [mthw_pkg::TIME_W-1:0] start);
		logic [1:0]                  idx [4];
		logic [mthw_pkg::TIME_W-1:0] val [4];
		idx[0] = mthw_pkg::CFG_TASK_TIMEOUT;   val[0] = {16'b0, tout};
		idx[1] = mthw_pkg::CFG_GRACE_PERIOD;   val[1] = {16'b0, grace};
		idx[2] = mthw_pkg::CFG_FAIL_THRESHOLD; val[2] = {40'b0, thresh};
		idx[3] = mthw_pkg::CFG_START_TIME;     val[3] = start;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic [mthw_pkg::TOUT_W-1:0] tout;
		logic [mthw_pkg::TOUT_W-1:0] grace;
		logic [mthw_pkg::FAIL_W-1:0] thresh;
		logic [mthw_pkg::TIME_W-1:0] start;
		case ($urandom_range(3))
			0:       tout = 32'd1;
			1:       tout = TOUT_MAX;
			default: tout = $urandom_range(2000, 1);
		endcase
		case ($urandom_range(4))
			0:       grace = '0;
			1:       grace = TOUT_MAX;
			default: grace = $urandom_range(3000, 0);
		endcase
		case ($urandom_range(3))
			0:       thresh = 8'd1;
			1:       thresh = 8'd255;
			default: thresh = mthw_pkg::FAIL_W'($urandom_range(6, 1));
		endcase
		case ($urandom_range(4))
			0:       start = '0;
			1:       start = TIME_MAX - rand_span(3000);
			2:       start = rand_time();
			default: start = rand_span(5000);
		endcase
		write_config(tout, grace, thresh, start);
		now_cursor = start + rand_span(4000);
	endtask

	// Mostly monotonic time with beats and checks; some random times and rewinds.
	task automatic random_events(input int count, input bit lock_always_fails);
		logic [mthw_pkg::IDX_W-1:0]  idx;
		logic [mthw_pkg::TIME_W-1:0] now;
		logic                        cmd;
		logic                        lock;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(19))
				0, 1:    now = rand_time();
				2:       now = now_cursor - rand_span(3000);
				default: begin
					now_cursor = now_cursor + rand_span(1200);
					now = now_cursor;
				end
			endcase
			idx = ($urandom_range(99) < 85) ?
				mthw_pkg::IDX_W'($urandom_range(mthw_pkg::NUM_TASKS - 1)) :
				mthw_pkg::IDX_W'($urandom_range(15));
			if (lock_always_fails) begin
				cmd  = ($urandom_range(99) < 90) ? mthw_pkg::CMD_CHECK : mthw_pkg::CMD_HEARTBEAT;
				lock = (cmd == mthw_pkg::CMD_CHECK) ? 1'b0 : 1'($urandom_range(1));
			end else begin
				cmd  = ($urandom_range(1) != 0) ? mthw_pkg::CMD_CHECK : mthw_pkg::CMD_HEARTBEAT;
				lock = ($urandom_range(99) >= 40);
			end
			send_item(cmd, idx, now, lock);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset-value settings
		send_item(mthw_pkg::CMD_CHECK, 4'd0, 48'd0, 1'b0);
		send_item(mthw_pkg::CMD_HEARTBEAT, 4'd0, 48'd0, 1'b0);
		send_item(mthw_pkg::CMD_HEARTBEAT, 4'd15, 48'd5, 1'b1);
		send_item(mthw_pkg::CMD_HEARTBEAT, 4'd8, 48'd5, 1'b0);
		send_item(mthw_pkg::CMD_HEARTBEAT, 4'd7, TIME_MAX, 1'b1);
		send_item(mthw_pkg::CMD_CHECK, 4'd3, 48'd40000000, 1'b1);
		repeat (4) send_item(mthw_pkg::CMD_CHECK, 4'd0, 48'd40000000, 1'b0);
		send_item(mthw_pkg::CMD_HEARTBEAT, 4'd0, 48'd40000000, 1'b0);
		send_item(mthw_pkg::CMD_CHECK, 4'hF, 48'd45000000, 1'b1);
		send_item(mthw_pkg::CMD_CHECK, 4'd0, TIME_MAX, 1'b1);
		drain();

		// zero threshold, zero grace, start at the top of the time range
		write_config(32'd1, '0, 8'd0, TIME_MAX);
		send_item(mthw_pkg::CMD_CHECK, 4'd0, TIME_MAX - 48'd1, 1'b0);
		send_item(mthw_pkg::CMD_CHECK, 4'd0, TIME_MAX, 1'b0);
		send_item(mthw_pkg::CMD_CHECK, 4'd0, TIME_MAX, 1'b1);
		send_item(mthw_pkg::CMD_HEARTBEAT, 4'd0, TIME_MAX, 1'b0);
		send_item(mthw_pkg::CMD_CHECK, 4'd0, TIME_MAX, 1'b1);
		drain();

		// long failure run up to counter saturation
		write_config(TOUT_MAX, '0, 8'd255, '0);
		now_cursor = '0;
		random_events(290, 1'b1);
		send_item(mthw_pkg::CMD_CHECK, 4'd0, now_cursor, 1'b1);
		drain();

		for (int p = 0; p < 8; p++) begin
			idle_mode = p % 4;
			random_config();
			random_events(22, 1'b0);
			drain();
		end
		idle_mode = 0;
		repeat (20) @(posedge clk);

		$display("covered %0d transactions (%0d checks), %0d verdicts compared",
			sb.events_seen, sb.checks_seen, sb.verdicts_seen);
		$display("UI-frozen requests %0d, stalled-task requests %0d",
			sb.frozen_seen, sb.stall_seen);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("multi_task_heartbeat_watchdog_core: match");
		else
			$display("multi_task_heartbeat_watchdog_core: mismatch");
		$finish;
	end

endmodule
